// ===== rtl/lvpt_pkg.sv =====
package lvpt_pkg;

	localparam int ADDR_W     = 64;
	localparam int VALUE_W    = 64;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_TRAIN  = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t              opcode;
		logic [ADDR_W-1:0]    pc;
		logic                 was_predicted;
		logic                 prediction_correct;
		logic [VALUE_W-1:0]   true_value;
	} req_t;

	typedef struct packed {
		logic                 predict_hit;
		logic [VALUE_W-1:0]   predicted_value;
	} rsp_t;

endpackage

// ===== rtl/lvpt_stream_if.sv =====
interface lvpt_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/lvpt_ram.sv =====
module lvpt_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/last_value_predictor_table_unit.sv =====
// Last-value predictor table.
// req channel: one transfer is a lookup (opcode OP_LOOKUP) or a training
//   update (OP_TRAIN) for the entry selected by pc.
// rsp channel: exactly one transfer per request, in order. Lookups return
//   predict_hit and, on a hit, the stored value; training updates return zeros.
// Storage is a single RAM of TABLE_ENTRIES words {counter, tag, value},
//   read by the stage ahead of the update stage; the last write is forwarded
//   to cover a read-modify-write on the same entry in back-to-back items.
// Throughput: with a power-of-two TABLE_ENTRIES the index is a bit slice
//   and one item is taken per cycle while rsp is not held; the request
//   passes the read stage, the update stage and the output register.
//   Otherwise each address nibble selects a constant residue, the residues
//   are summed in two registered steps and reduced by compare and subtract
//   in a third; the next request is taken only once that index is ready.
// Reset: all control clears, then a clearing pass writes zero to every
//   entry, one per cycle; req.ready stays low during that pass.
// Stall: a held rsp keeps its result in the output register; the pipeline
//   behind it fills and req.ready drops once no stage can move.
module last_value_predictor_table_unit
	import lvpt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 1024,
	parameter int COUNTER_BITS  = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	lvpt_stream_if.sink   req,
	lvpt_stream_if.source rsp
);

	localparam int IDX_W   = $clog2(TABLE_ENTRIES);
	localparam int TAG_W   = ADDR_W - COUNTER_BITS;
	localparam int ENTRY_W = COUNTER_BITS + TAG_W + VALUE_W;
	localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
	localparam logic [COUNTER_BITS-1:0] CTR_MAX = {COUNTER_BITS{1'b1}};

	typedef struct packed {
		logic [COUNTER_BITS-1:0] ctr;
		logic [TAG_W-1:0]        tag;
		logic [VALUE_W-1:0]      value;
	} entry_t;

	logic              clr_active_q;
	logic [IDX_W-1:0]  clr_idx_q;

	logic              s0_valid_q;
	opcode_t           s0_opcode_q;
	logic [TAG_W-1:0]  s0_tag_q;
	logic              s0_pred_q;
	logic              s0_corr_q;
	logic [VALUE_W-1:0] s0_value_q;
	logic [IDX_W-1:0]  s0_idx;
	logic              s0_done;

	logic              s1_valid_q;
	opcode_t           s1_opcode_q;
	logic [TAG_W-1:0]  s1_tag_q;
	logic              s1_pred_q;
	logic              s1_corr_q;
	logic [VALUE_W-1:0] s1_value_q;
	logic [IDX_W-1:0]  s1_idx_q;

	logic              fwd_valid_q;
	logic [IDX_W-1:0]  fwd_idx_q;
	entry_t            fwd_entry_q;

	logic              out_valid_q;
	rsp_t              out_data_q;

	logic              req_fire;
	logic              s0_adv;
	logic              s1_fire;
	logic              s1_write;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [ENTRY_W-1:0] mem_rdata;

	entry_t            cur_entry;
	entry_t            new_entry;
	logic              tag_hit;
	logic              ctr_sat;
	logic [COUNTER_BITS-1:0] ctr_inc;
	rsp_t              s1_rsp;

	assign s1_fire   = s1_valid_q && (!out_valid_q || rsp.ready);
	assign s0_adv    = s0_valid_q && s0_done && (!s1_valid_q || s1_fire);
	assign req.ready = !clr_active_q && (!s0_valid_q || s0_adv);
	assign req_fire  = req.valid && req.ready;
	assign s1_write  = s1_fire && (s1_opcode_q == OP_TRAIN);

	generate
		if (IS_POW2) begin : g_slice_idx
			logic [IDX_W-1:0] idx_q;

			always_ff @(posedge clk) begin
				if (req_fire) begin
					idx_q <= req.data.pc[IDX_W-1:0];
				end
			end

			assign s0_idx  = idx_q;
			assign s0_done = 1'b1;
		end else begin : g_rem_idx
			localparam int NIBBLES = ADDR_W / 4;
			localparam int SUM_W   = IDX_W + 4;
			localparam logic [SUM_W-1:0] MOD_N = SUM_W'(TABLE_ENTRIES);

			logic [ADDR_W-1:0] addr_q;
			logic [SUM_W-1:0]  part_q [4];
			logic [SUM_W-1:0]  sum_q;
			logic [IDX_W-1:0]  rem_q;
			logic [1:0]        step_q;
			logic [IDX_W-1:0]  nib_res [NIBBLES];
			logic [SUM_W-1:0]  part_d [4];
			logic [SUM_W-1:0]  sum_d;
			logic [SUM_W-1:0]  red_d;

			// residue of each nibble value at its position
			for (genvar k = 0; k < NIBBLES; k++) begin : g_nib
				logic [IDX_W-1:0] res_tab [16];
				for (genvar c = 0; c < 16; c++) begin : g_res
					assign res_tab[c] =
						IDX_W'((ADDR_W'(c) << (4 * k)) % ADDR_W'(TABLE_ENTRIES));
				end
				assign nib_res[k] = res_tab[addr_q[4*k +: 4]];
			end

			always_comb begin
				for (int j = 0; j < 4; j++) begin
					part_d[j] = '0;
					for (int k = 0; k < 4; k++) begin
						part_d[j] = part_d[j] + SUM_W'(nib_res[4*j + k]);
					end
				end
				sum_d = '0;
				for (int j = 0; j < 4; j++) begin
					sum_d = sum_d + part_q[j];
				end
				red_d = sum_q;
				for (int j = 3; j >= 0; j--) begin
					if (red_d >= (MOD_N << j)) begin
						red_d = red_d - (MOD_N << j);
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					step_q <= '0;
				end else if (req_fire) begin
					step_q <= '0;
				end else if (s0_valid_q && !s0_done) begin
					step_q <= step_q + 2'd1;
				end
			end

			always_ff @(posedge clk) begin
				if (req_fire) begin
					addr_q <= req.data.pc;
				end
				part_q <= part_d;
				sum_q  <= sum_d;
				rem_q  <= red_d[IDX_W-1:0];
			end

			assign s0_done = step_q == 2'd3;
			assign s0_idx  = rem_q;
		end
	endgenerate

	assign mem_we    = clr_active_q || s1_write;
	assign mem_waddr = clr_active_q ? clr_idx_q : s1_idx_q;
	assign mem_wdata = clr_active_q ? '0 : ENTRY_W'(new_entry);

	lvpt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (s0_adv),
		.raddr (s0_idx),
		.rdata (mem_rdata)
	);

	always_comb begin
		cur_entry = (fwd_valid_q && fwd_idx_q == s1_idx_q) ? fwd_entry_q : entry_t'(mem_rdata);
		tag_hit   = cur_entry.tag == s1_tag_q;
		ctr_sat   = cur_entry.ctr == CTR_MAX;
		ctr_inc   = ctr_sat ? cur_entry.ctr : cur_entry.ctr + COUNTER_BITS'(1);

		new_entry = cur_entry;
		if (s1_pred_q) begin
			if (s1_corr_q) begin
				new_entry.ctr = ctr_inc;
			end else begin
				new_entry.ctr   = '0;
				new_entry.value = s1_value_q;
			end
		end else if (tag_hit) begin
			new_entry.ctr   = ctr_inc;
			new_entry.value = s1_value_q;
		end else begin
			new_entry.tag   = s1_tag_q;
			new_entry.ctr   = '0;
			new_entry.value = s1_value_q;
		end

		s1_rsp = '0;
		if (s1_opcode_q == OP_LOOKUP && ctr_sat && tag_hit) begin
			s1_rsp.predict_hit     = 1'b1;
			s1_rsp.predicted_value = cur_entry.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_idx_q    <= '0;
			s0_valid_q   <= 1'b0;
			s1_valid_q   <= 1'b0;
			fwd_valid_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (clr_active_q) begin
				if (clr_idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
					clr_active_q <= 1'b0;
				end
				clr_idx_q <= clr_idx_q + IDX_W'(1);
			end
			if (req_fire) begin
				s0_valid_q <= 1'b1;
			end else if (s0_adv) begin
				s0_valid_q <= 1'b0;
			end
			if (s0_adv) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_write) begin
				fwd_valid_q <= 1'b1;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			s0_opcode_q <= req.data.opcode;
			s0_tag_q    <= req.data.pc[ADDR_W-1:COUNTER_BITS];
			s0_pred_q   <= req.data.was_predicted;
			s0_corr_q   <= req.data.prediction_correct;
			s0_value_q  <= req.data.true_value;
		end
		if (s0_adv) begin
			s1_opcode_q <= s0_opcode_q;
			s1_tag_q    <= s0_tag_q;
			s1_pred_q   <= s0_pred_q;
			s1_corr_q   <= s0_corr_q;
			s1_value_q  <= s0_value_q;
			s1_idx_q    <= s0_idx;
		end
		if (s1_write) begin
			fwd_idx_q   <= s1_idx_q;
			fwd_entry_q <= new_entry;
		end
		if (s1_fire) begin
			out_data_q <= s1_rsp;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

	a_lookup_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && s1_opcode_q == OP_LOOKUP) |-> !mem_we)
		else $error("lookup wrote the table");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> (!s0_valid_q && !s1_valid_q && !out_valid_q))
		else $error("item in flight during clearing pass");

	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> out_valid_q)
		else $error("update stage transfer lost");

	a_s0_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s0_adv |=> s1_valid_q)
		else $error("read stage transfer lost");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_data_q.predict_hit) |-> (out_data_q.predicted_value == '0))
		else $error("nonzero value without a hit");

endmodule

// ===== sim/last_value_predictor_table_unit_tb.sv =====
`timescale 1ns / 100ps

module last_value_predictor_table_unit_tb;
	import lvpt_pkg::*;

	localparam int TABLE_ENTRIES = 1024;
	localparam int COUNTER_BITS  = 2;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int TAG_W         = ADDR_W - COUNTER_BITS;
	localparam int RAND_ITEMS    = 1400;
	localparam int HOT_CNT       = 12;
	localparam int CYCLE_LIMIT   = 200000;
	localparam logic [COUNTER_BITS-1:0] CTR_MAX = '1;

	typedef struct {
		req_t item;
		bit   fixed;
		rsp_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	lvpt_stream_if #(.T(req_t)) req_if ();
	lvpt_stream_if #(.T(rsp_t)) rsp_if ();

	last_value_predictor_table_unit #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.COUNTER_BITS (COUNTER_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	// predictor state
	logic [COUNTER_BITS-1:0] conf_ctr [TABLE_ENTRIES];
	logic [TAG_W-1:0]        ent_tag  [TABLE_ENTRIES];
	logic [VALUE_W-1:0]      last_val [TABLE_ENTRIES];

	rsp_t        pred_q [$];
	stim_row_t   dir_q [$];
	logic [63:0] hot_addr [HOT_CNT];

	// fixed expectation travels with the transfer it belongs to
	bit   row_fixed;
	rsp_t row_want;

	bit calm;
	int err_cnt;
	int cyc;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic bit entry_hit(logic [ADDR_W-1:0] a);
		logic [IDX_W-1:0] ix;
		ix = IDX_W'(a % ADDR_W'(TABLE_ENTRIES));
		return conf_ctr[ix] == CTR_MAX && ent_tag[ix] == TAG_W'(a >> COUNTER_BITS);
	endfunction

	function automatic rsp_t lvp_apply(req_t r);
		rsp_t             o;
		logic [IDX_W-1:0] ix;
		logic [TAG_W-1:0] tag;
		bit               tag_hit;
		o = '0;
		ix = IDX_W'(r.pc % ADDR_W'(TABLE_ENTRIES));
		tag = TAG_W'(r.pc >> COUNTER_BITS);
		tag_hit = ent_tag[ix] == tag;
		if (r.opcode == OP_LOOKUP) begin
			if (conf_ctr[ix] == CTR_MAX && tag_hit) begin
				o.predict_hit = 1'b1;
				o.predicted_value = last_val[ix];
			end
			return o;
		end
		if (r.was_predicted) begin
			if (r.prediction_correct) begin
				if (conf_ctr[ix] != CTR_MAX)
					conf_ctr[ix] = conf_ctr[ix] + COUNTER_BITS'(1);
			end else begin
				conf_ctr[ix] = '0;
				last_val[ix] = r.true_value;
			end
		end else if (tag_hit) begin
			if (conf_ctr[ix] != CTR_MAX)
				conf_ctr[ix] = conf_ctr[ix] + COUNTER_BITS'(1);
			last_val[ix] = r.true_value;
		end else begin
			ent_tag[ix] = tag;
			conf_ctr[ix] = '0;
			last_val[ix] = r.true_value;
		end
		return o;
	endfunction

	// mostly training sequences on a few hot addresses (some sharing an index),
	// the rest fully random
	function automatic req_t make_item();
		req_t             r;
		int unsigned      pick;
		logic [IDX_W-1:0] ix;
		bit               hit;
		pick = $urandom_range(0, 99);
		r.opcode = ($urandom_range(0, 9) < 4) ? OP_LOOKUP : OP_TRAIN;
		r.was_predicted = 1'($urandom_range(0, 1));
		r.prediction_correct = 1'($urandom_range(0, 1));
		r.true_value = rand64();
		if (pick >= 85) begin
			r.pc = rand64();
			return r;
		end
		r.pc = hot_addr[$urandom_range(0, HOT_CNT - 1)];
		if (r.opcode == OP_TRAIN) begin
			ix = IDX_W'(r.pc % ADDR_W'(TABLE_ENTRIES));
			hit = entry_hit(r.pc);
			r.was_predicted = ($urandom_range(0, 9) == 0) ? !hit : hit;
			if ($urandom_range(0, 1))
				r.true_value = last_val[ix];
			r.prediction_correct = (r.true_value == last_val[ix]);
			if ($urandom_range(0, 9) == 0)
				r.prediction_correct = !r.prediction_correct;
		end
		return r;
	endfunction

	task automatic add_row(input opcode_t op, input logic [63:0] a, input bit wp,
			input bit pc, input logic [63:0] tv, input bit fx, input bit h,
			input logic [63:0] v);
		stim_row_t row;
		row.item.opcode = op;
		row.item.pc = a;
		row.item.was_predicted = wp;
		row.item.prediction_correct = pc;
		row.item.true_value = tv;
		row.fixed = fx;
		row.want.predict_hit = h;
		row.want.predicted_value = v;
		dir_q.push_back(row);
	endtask

	task automatic send_req(input req_t item, input bit fx, input rsp_t want);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= item;
		row_fixed <= fx;
		row_want <= want;
		do @(posedge clk); while (!req_if.ready);
	endtask

	task automatic drain();
		while (pred_q.size() != 0)
			@(posedge clk);
	endtask

	// prediction and checking, both on transfers seen at the same edge
	always @(posedge clk) begin
		rsp_t got;
		rsp_t exp_rsp;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (pred_q.size() == 0) begin
					err_cnt++;
					$display("%0t: response with none expected: hit %0b value %h",
						$time, rsp_if.data.predict_hit, rsp_if.data.predicted_value);
				end else begin
					exp_rsp = pred_q.pop_front();
					if (rsp_if.data.predict_hit !== exp_rsp.predict_hit) begin
						err_cnt++;
						$display("%0t: predict_hit expected %0b actual %0b", $time,
							exp_rsp.predict_hit, rsp_if.data.predict_hit);
					end
					if (rsp_if.data.predicted_value !== exp_rsp.predicted_value) begin
						err_cnt++;
						$display("%0t: predicted_value expected %h actual %h", $time,
							exp_rsp.predicted_value, rsp_if.data.predicted_value);
					end
				end
			end
			if (req_if.valid && req_if.ready) begin
				got = lvp_apply(req_if.data);
				pred_q.push_back(row_fixed ? row_want : got);
			end
		end else begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				conf_ctr[i] = '0;
				ent_tag[i] = '0;
				last_val[i] = '0;
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d responses outstanding", $time, pred_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// response side
	initial begin
		int unsigned stall;
		rsp_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
		end
	end

	initial begin
		localparam logic [63:0] A_ZERO  = 64'h0;
		localparam logic [63:0] A_ONES  = '1;
		localparam logic [63:0] A_ALIAS = 64'h400;
		localparam logic [63:0] A_HIGH  = 64'h3FF;
		stim_row_t   row;
		rsp_t        none;
		req_t        item;
		logic [63:0] upper;
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.data <= '0;
		row_fixed <= 1'b0;
		row_want <= '0;
		calm = 1'b0;
		none = '0;

		hot_addr[0] = A_ZERO;
		hot_addr[1] = A_ONES;
		for (int i = 2; i < HOT_CNT; i++)
			hot_addr[i] = rand64();
		for (int i = 6; i < 10; i++) begin
			upper = rand64();
			hot_addr[i] = {upper[63:IDX_W], hot_addr[i-4][IDX_W-1:0]};
		end

		// directed part: reset state, counter climb, ignored lookup fields,
		// aliasing on one index, predicted update with a foreign tag
		add_row(OP_LOOKUP, A_ZERO, 0, 0, '0, 1, 0, '0);
		add_row(OP_LOOKUP, A_ONES, 1, 1, '1, 1, 0, '0);
		add_row(OP_TRAIN,  A_ZERO, 0, 0, '1, 1, 0, '0);
		add_row(OP_TRAIN,  A_ZERO, 0, 0, 64'h0123_4567_89AB_CDEF, 1, 0, '0);
		add_row(OP_LOOKUP, A_ZERO, 1, 1, 64'hDEAD_BEEF_0000_0001, 1, 0, '0);
		add_row(OP_TRAIN,  A_ZERO, 0, 1, '1, 1, 0, '0);
		add_row(OP_LOOKUP, A_ZERO, 0, 0, '0, 1, 1, '1);
		add_row(OP_LOOKUP, A_ZERO, 1, 0, '0, 1, 1, '1);
		add_row(OP_TRAIN,  A_ZERO, 1, 1, '0, 1, 0, '0);
		add_row(OP_LOOKUP, A_ZERO, 0, 1, '1, 1, 1, '1);
		add_row(OP_TRAIN,  A_ZERO, 1, 0, 64'hA5A5_A5A5_A5A5_A5A5, 1, 0, '0);
		add_row(OP_LOOKUP, A_ZERO, 0, 0, '0, 0, 0, '0);
		add_row(OP_TRAIN,  A_ALIAS, 0, 0, 64'h5A5A_5A5A_5A5A_5A5A, 0, 0, '0);
		add_row(OP_LOOKUP, A_ZERO, 0, 0, '0, 0, 0, '0);
		add_row(OP_TRAIN,  A_ONES, 0, 0, '0, 0, 0, '0);
		add_row(OP_TRAIN,  A_ONES, 0, 1, '1, 0, 0, '0);
		add_row(OP_TRAIN,  A_ONES, 0, 0, 64'h8000_0000_0000_0001, 0, 0, '0);
		add_row(OP_TRAIN,  A_ONES, 0, 0, 64'h8000_0000_0000_0001, 0, 0, '0);
		add_row(OP_LOOKUP, A_ONES, 0, 0, '0, 0, 0, '0);
		add_row(OP_TRAIN,  A_HIGH, 1, 1, 64'h7FFF_FFFF_FFFF_FFFE, 0, 0, '0);
		add_row(OP_LOOKUP, A_ONES, 0, 0, '0, 0, 0, '0);
		add_row(OP_LOOKUP, A_HIGH, 0, 0, '0, 0, 0, '0);
		add_row(OP_TRAIN,  A_HIGH, 1, 0, '0, 0, 0, '0);
		add_row(OP_LOOKUP, A_ONES, 0, 0, '0, 0, 0, '0);
		add_row(OP_TRAIN,  A_ONES, 0, 0, '1, 0, 0, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_q[i]) begin
			row = dir_q[i];
			send_req(row.item, row.fixed, row.want);
		end
		req_if.valid <= 1'b0;
		drain();

		for (int n = 0; n < RAND_ITEMS; n++) begin
			calm = ((n / 150) % 4) == 3;
			if (n == RAND_ITEMS / 2) begin
				req_if.valid <= 1'b0;
				drain();
			end
			item = make_item();
			send_req(item, 1'b0, none);
		end
		req_if.valid <= 1'b0;
		drain();
		repeat (8) @(posedge clk);

		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
